### src/multi_objective_td_update_core_macros.svh
// assertion macros shared by the td update core rtl
`ifndef MULTI_OBJECTIVE_TD_UPDATE_CORE_MACROS_SVH
`define MULTI_OBJECTIVE_TD_UPDATE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define MOTD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MOTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/motd_pkg.sv
// types, codes and microcode program of the td update core
package motd_pkg;

    localparam int STATE_W   = 6;
    localparam int ACTION_W  = 4;
    localparam int STATE_CODES  = 1 << STATE_W;
    localparam int ACTION_CODES = 1 << ACTION_W;

    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic signed [15:0] REWARD_ONE = -16'sd256;

    localparam logic [15:0] ALPHA_RST = 16'd45875;
    localparam logic [15:0] GAMMA_RST = 16'd58982;

    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_GAMMA = 1'b1;

    typedef struct packed {
        logic [1:0]          op;
        logic [STATE_W-1:0]  cur_state;
        logic [ACTION_W-1:0] cur_action;
        logic [STATE_W-1:0]  succ_state;
        logic [ACTION_W-1:0] succ_action;
        logic signed [15:0]  reward_zero;
        logic                terminal;
        logic                objective_sel;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] td_error_zero;
        logic signed [15:0] td_error_one;
        logic signed [15:0] q_value;
    } t_out_item;

    typedef logic [3:0] t_pc;

    typedef enum logic [1:0] {
        C_NEXT  = 2'd0,
        C_LOOP  = 2'd1,
        C_SWEEP = 2'd2,
        C_END   = 2'd3
    } t_cond;

    typedef struct packed {
        logic  rd_en;
        logic  rd_nxt;
        logic  mul_gamma;
        logic  mul_alpha;
        logic  diff_load;
        logic  err_load;
        logic  wr_q;
        logic  wr_zero;
        logic  out_mem;
        logic  out_zero;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        logic       obj_sel;
        logic       sweep_done;
    } t_seq_stat;

    // program entry points
    localparam t_pc PC_UPDATE = 4'd0;
    localparam t_pc PC_WB     = 4'd5;
    localparam t_pc PC_READ   = 4'd6;
    localparam t_pc PC_EMIT   = 4'd7;
    localparam t_pc PC_CLEAR  = 4'd8;
    localparam t_pc PC_NOP    = 4'd9;
    localparam t_pc PC_INIT   = 4'd10;
    localparam t_pc PC_IDLE   = 4'd11;
    localparam t_pc PC_LAST   = PC_IDLE;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '0;
        w.cond = C_NEXT;
        case (pc)
            4'd0: begin
                w.rd_en  = 1'b1;
                w.rd_nxt = 1'b1;
            end
            4'd1: begin
                w.rd_en     = 1'b1;
                w.mul_gamma = 1'b1;
            end
            4'd2: w.diff_load = 1'b1;
            4'd3: w.mul_alpha = 1'b1;
            4'd4: w.err_load  = 1'b1;
            PC_WB: begin
                w.wr_q   = 1'b1;
                w.cond   = C_LOOP;
                w.target = PC_UPDATE;
            end
            PC_READ: w.rd_en = 1'b1;
            PC_EMIT: begin
                w.out_mem = 1'b1;
                w.cond    = C_END;
            end
            PC_CLEAR: begin
                w.wr_zero = 1'b1;
                w.cond    = C_SWEEP;
                w.target  = PC_NOP;
            end
            PC_NOP: begin
                w.out_zero = 1'b1;
                w.cond     = C_END;
            end
            PC_INIT: begin
                w.wr_zero = 1'b1;
                w.cond    = C_SWEEP;
                w.target  = PC_IDLE;
            end
            PC_IDLE: w.cond = C_END;
            default: w.cond = C_END;
        endcase
        return w;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

### src/motd_seq.sv
// microcode sequencer: step counter, program rom and objective loop
module motd_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  motd_pkg::t_seq_stat i_stat,
    output logic                o_busy,
    output logic                o_obj,
    output motd_pkg::t_uword    o_ctrl
);
    import motd_pkg::*;

    logic   r_busy, n_busy;
    t_pc    r_pc, n_pc;
    logic   r_obj, n_obj;
    t_uword w_uw;

    assign w_uw = ucode(r_pc);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_obj  = r_obj;
        if (!r_busy) begin
            if (i_stat.start) begin
                n_busy = 1'b1;
                n_obj  = 1'b0;
                case (i_stat.op)
                    OP_UPDATE: n_pc = PC_UPDATE;
                    OP_READ: begin
                        n_pc  = PC_READ;
                        n_obj = i_stat.obj_sel;
                    end
                    OP_CLEAR: n_pc = PC_CLEAR;
                    default:  n_pc = PC_NOP;
                endcase
            end
        end else begin
            case (w_uw.cond)
                C_NEXT: n_pc = r_pc + 4'd1;
                C_LOOP: begin
                    // objective 0 done: run the same steps for objective 1
                    if (!r_obj) begin
                        n_obj = 1'b1;
                        n_pc  = w_uw.target;
                    end else begin
                        n_obj = 1'b0;
                        n_pc  = r_pc + 4'd1;
                    end
                end
                C_SWEEP: begin
                    if (i_stat.sweep_done) begin
                        n_pc = w_uw.target;
                    end
                end
                C_END:   n_busy = 1'b0;
                default: n_busy = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_pc   <= PC_INIT;
            r_obj  <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_obj  <= n_obj;
        end
    end

    assign o_busy = r_busy;
    assign o_obj  = r_obj;
    assign o_ctrl = r_busy ? w_uw : '0;

endmodule

### src/multi_objective_td_update_core.sv
// top level: config registers, q table memory and td datapath
//
// Two-objective SARSA TD engine. An item is taken when start is high and
// busy is low; op selects update, read, clear or no-op. Every item gives
// exactly one result on o_result, shown for one cycle with o_done high;
// the receiver cannot stall, so the result must be taken in that cycle.
// The result cycle is also the first cycle in which a new item can be
// accepted. The steps of each op:
//   update: two objectives, each two table reads, two multiplies and a
//           write-back on the single-port q table, then a read-back
//   read:   a table read, then the result; no-op: the result only
//   clear:  the whole table zeroed (one table entry zeroed per cycle)
// The single memory port and the one shared multiplier set these steps.
// After reset the block sweeps the whole table to zero, one entry a cycle,
// with busy high; config writes are taken during that sweep. learning_rate
// sits at byte address 0, discount at 4, both unsigned Q0.16 in pwdata[15:0];
// write them only while idle.
module multi_objective_td_update_core #(
    parameter int NUM_STATES  = 64,
    parameter int NUM_ACTIONS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    input  motd_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_done,
    output motd_pkg::t_out_item  o_result
);
    import motd_pkg::*;
    `include "multi_objective_td_update_core_macros.svh"

    localparam int TABLE_OFS = NUM_STATES * NUM_ACTIONS;
    localparam int DEPTH     = 2 * TABLE_OFS;
    localparam int MAW       = $clog2(DEPTH);
    localparam int SW        = $clog2(NUM_STATES);
    localparam int AW        = $clog2(NUM_ACTIONS);

    typedef logic [STATE_CODES-1:0][SW-1:0]  t_state_map;
    typedef logic [ACTION_CODES-1:0][AW-1:0] t_action_map;

    // index wrap as constant lookup tables
    function automatic t_state_map build_state_map();
        t_state_map m;
        for (int i = 0; i < STATE_CODES; i++) begin
            m[i] = SW'(i % NUM_STATES);
        end
        return m;
    endfunction

    function automatic t_action_map build_action_map();
        t_action_map m;
        for (int i = 0; i < ACTION_CODES; i++) begin
            m[i] = AW'(i % NUM_ACTIONS);
        end
        return m;
    endfunction

    localparam t_state_map  STATE_MAP  = build_state_map();
    localparam t_action_map ACTION_MAP = build_action_map();

    // config registers
    logic [15:0] r_alpha;
    logic [15:0] r_gamma;
    logic        w_cfg_wr;

    // sequencer
    t_seq_stat w_stat;
    t_uword    w_ctrl;
    logic      w_obj;
    logic      w_busy;

    // datapath
    t_in_item           r_item;
    logic [15:0]        r_mem [DEPTH];
    logic signed [15:0] r_rdata;
    logic signed [34:0] r_prod;
    logic signed [17:0] r_diff;
    logic signed [15:0] r_q;
    logic signed [15:0] r_err;
    logic signed [15:0] r_last0;
    logic signed [15:0] r_last1;
    logic [MAW-1:0]     r_clr;
    logic               r_done;
    t_out_item          r_result;

    logic [SW-1:0]      w_cur_s, w_nxt_s;
    logic [AW-1:0]      w_cur_a, w_nxt_a;
    logic [MAW-1:0]     w_base, w_addr_cur, w_addr_nxt, w_raddr, w_waddr;
    logic               w_we;
    logic [15:0]        w_wdata;
    logic               w_sweep_done;
    logic signed [17:0] w_mul_a;
    logic signed [16:0] w_mul_b;
    logic signed [34:0] w_prod;
    logic signed [35:0] w_rsum;
    logic signed [19:0] w_rnd;
    logic signed [15:0] w_reward;
    logic signed [17:0] w_boot;
    logic signed [17:0] w_diff;
    logic signed [15:0] w_err;

    assign w_cfg_wr = psel & penable & pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_GAMMA) ? {16'd0, r_gamma} : {16'd0, r_alpha};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
            r_gamma <= GAMMA_RST;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_GAMMA) begin
                r_gamma <= pwdata[15:0];
            end else begin
                r_alpha <= pwdata[15:0];
            end
        end
    end

    assign w_stat.start      = start;
    assign w_stat.op         = i_item.op;
    assign w_stat.obj_sel    = i_item.objective_sel;
    assign w_stat.sweep_done = w_sweep_done;

    motd_seq u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_stat (w_stat),
        .o_busy (w_busy),
        .o_obj  (w_obj),
        .o_ctrl (w_ctrl)
    );

    assign busy = w_busy;

    always_ff @(posedge i_clk) begin
        if (start && !w_busy) begin
            r_item <= i_item;
        end
    end

    // table addresses: entry (obj, s, a) at (obj*S + s)*A + a
    assign w_cur_s    = STATE_MAP[r_item.cur_state];
    assign w_nxt_s    = STATE_MAP[r_item.succ_state];
    assign w_cur_a    = ACTION_MAP[r_item.cur_action];
    assign w_nxt_a    = ACTION_MAP[r_item.succ_action];
    assign w_base     = w_obj ? MAW'(TABLE_OFS) : '0;
    assign w_addr_cur = w_base + MAW'(MAW'(w_cur_s) * MAW'(NUM_ACTIONS)) + MAW'(w_cur_a);
    assign w_addr_nxt = w_base + MAW'(MAW'(w_nxt_s) * MAW'(NUM_ACTIONS)) + MAW'(w_nxt_a);

    assign w_sweep_done = (r_clr == MAW'(DEPTH - 1));
    assign w_raddr      = w_ctrl.rd_nxt ? w_addr_nxt : w_addr_cur;
    assign w_waddr      = w_ctrl.wr_zero ? r_clr : w_addr_cur;
    assign w_we         = w_ctrl.wr_q | w_ctrl.wr_zero;
    assign w_wdata      = w_ctrl.wr_zero ? 16'd0 : sat16(20'(r_q) + 20'(r_err));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_ctrl.rd_en) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (w_ctrl.wr_zero) begin
            r_clr <= w_sweep_done ? '0 : r_clr + MAW'(1);
        end
    end

    // shared multiplier: gamma*Q(next) first, alpha*diff later
    assign w_mul_a = w_ctrl.mul_gamma ? 18'(r_rdata) : r_diff;
    assign w_mul_b = signed'({1'b0, w_ctrl.mul_gamma ? r_gamma : r_alpha});
    assign w_prod  = w_mul_a * w_mul_b;

    // round to nearest, ties up: floor((p + 2^15) / 2^16)
    assign w_rsum = 36'(r_prod) + 36'sd32768;
    assign w_rnd  = w_rsum[35:16];

    assign w_reward = w_obj ? REWARD_ONE : r_item.reward_zero;
    assign w_boot   = r_item.terminal ? '0 : 18'(w_rnd);
    assign w_diff   = 18'(w_reward) - 18'(r_rdata) + w_boot;
    assign w_err    = sat16(w_rnd);

    always_ff @(posedge i_clk) begin
        if (w_ctrl.mul_gamma | w_ctrl.mul_alpha) begin
            r_prod <= w_prod;
        end
        if (w_ctrl.diff_load) begin
            r_diff <= w_diff;
            r_q    <= r_rdata;
        end
        if (w_ctrl.err_load) begin
            r_err <= w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last0 <= '0;
            r_last1 <= '0;
        end else if (w_ctrl.err_load) begin
            if (w_obj) begin
                r_last1 <= w_err;
            end else begin
                r_last0 <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_ctrl.out_mem | w_ctrl.out_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_mem | w_ctrl.out_zero) begin
            r_result.td_error_zero <= r_last0;
            r_result.td_error_one  <= r_last1;
            r_result.q_value       <= w_ctrl.out_mem ? r_rdata : 16'sd0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    `MOTD_ASSERT_SAME(a_done_idle, o_done, !busy, "result shown while still busy")
    `MOTD_ASSERT_NEXT(a_no_early_done, start && !busy, !o_done, "result right after accept")
    `MOTD_ASSERT_SAME(a_clr_range, 1'b1, r_clr <= MAW'(DEPTH - 1), "sweep address out of range")
    `MOTD_ASSERT_SAME(a_one_port, w_ctrl.rd_en, !w_we, "table read and written in one step")

endmodule
